FILE: rtl/pwm_pdp_pkg.sv
// Shared types, constants and register map of the PWM period divider planner.
package pwm_pdp_pkg;

  localparam int unsigned MAX_COUNTER_BITS = 32;
  localparam int unsigned MAX_DIVIDER_BITS = 24;
  localparam int unsigned MAX_FRAC_BITS    = 16;

  localparam int unsigned PERIOD_W = 64;
  localparam int unsigned CLOCK_W  = 33;
  localparam int unsigned CW_W     = 6;
  localparam int unsigned IW_W     = 5;
  localparam int unsigned FW_W     = 5;
  localparam int unsigned TOP_W    = 32;
  localparam int unsigned DIV_W    = MAX_DIVIDER_BITS;
  localparam int unsigned ACC_W    = 96;
  localparam int unsigned DEN_W    = 56;
  localparam int unsigned APB_DW   = 64;
  localparam int unsigned APB_AW   = 5;

  localparam logic [31:0] NS_PER_SEC = 32'd1_000_000_000;

  // Register indexes (byte address / 8)
  localparam logic [1:0] REG_CLK_FREQ  = 2'd0;
  localparam logic [1:0] REG_CNT_WIDTH = 2'd1;
  localparam logic [1:0] REG_INT_WIDTH = 2'd2;
  localparam logic [1:0] REG_FRC_WIDTH = 2'd3;

  localparam logic [CLOCK_W-1:0] CLK_FREQ_RST  = 33'd125_000_000;
  localparam logic [CW_W-1:0]    CNT_WIDTH_RST = 6'd16;
  localparam logic [IW_W-1:0]    INT_WIDTH_RST = 5'd8;
  localparam logic [FW_W-1:0]    FRC_WIDTH_RST = 5'd4;

  typedef struct packed {
    logic [CLOCK_W-1:0] clk_freq;
    logic [CW_W-1:0]    counter_width;
    logic [IW_W-1:0]    divider_int_width;
    logic [FW_W-1:0]    divider_frac_width;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_PC_LO,
    MUL_PC_HI,
    MUL_CAND,
    MUL_CL,
    MUL_M_LO,
    MUL_M_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI,
    ACC_TICKS
  } acc_op_e;

  typedef enum logic [1:0] {
    CAND_ONE,
    CAND_LIMIT,
    CAND_MID,
    CAND_LO
  } cand_sel_e;

  typedef enum logic {
    DEN_CAND,
    DEN_CLOCK
  } den_sel_e;

  typedef struct packed {
    logic      ld_period;
    mul_sel_e  mul_sel;
    acc_op_e   acc_op;
    logic      ld_ticks;
    logic      ld_cand;
    cand_sel_e cand_sel;
    logic      srch_init;
    logic      srch_hi;
    logic      srch_lo;
    logic      div_start;
    den_sel_e  den_sel;
    logic      ld_counts;
    logic      res_ok;
    logic      res_err;
  } cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic period_nz;
    logic ticks_ovf;
    logic div_done;
    logic div_ovf;
    logic cnt_ge2;
    logic cnt_fits;
    logic lo_lt_hi;
  } sts_t;

endpackage

FILE: rtl/pwm_pdp_div.sv
// Iterative rounded divider: 96-bit numerator by 56-bit denominator, one bit a cycle.
module pwm_pdp_div import pwm_pdp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ACC_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic               ovf_o,
  output logic [63:0]        quo_o
);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_RUN  = 4'b0010,
    DV_RND  = 4'b0100,
    DV_INC  = 4'b1000
  } dv_state_e;

  dv_state_e        state_q, state_d;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [63:0]      quo_q;
  logic [5:0]       cnt_q;
  logic             rnd_q, done_q, ovf_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;
  logic [DEN_W-1:0] num_hi;

  assign num_hi = {{(DEN_W-32){1'b0}}, num_i[ACC_W-1:64]};
  assign trial  = {rem_q, quo_q[63]};
  assign ge     = trial >= {1'b0, den_q};
  assign diff   = trial - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (start_i && num_hi < den_i) state_d = DV_RUN;
      DV_RUN:  if (cnt_q == 6'd0) state_d = DV_RND;
      DV_RND:  state_d = DV_INC;
      DV_INC:  state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == DV_IDLE && start_i && num_hi >= den_i) begin
        done_q <= 1'b1;
        ovf_q  <= 1'b1;
      end else if (state_q == DV_INC) begin
        done_q <= 1'b1;
        ovf_q  <= (&quo_q) & rnd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          den_q <= den_i;
          rem_q <= num_hi;
          quo_q <= num_i[63:0];
          cnt_q <= 6'd63;
        end
      end
      DV_RUN: begin
        rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q - 6'd1;
      end
      DV_RND: rnd_q <= {rem_q, 1'b0} >= {1'b0, den_q};
      DV_INC: quo_q <= quo_q + {63'd0, rnd_q};
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/pwm_pdp_dp.sv
// Datapath: operand registers, shared multiplier, accumulator, search bounds, divider.
module pwm_pdp_dp import pwm_pdp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic [PERIOD_W-1:0] period_ns_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                result_valid_o,
  output logic                status_o,
  output logic [TOP_W-1:0]    top_value_o,
  output logic [DIV_W-1:0]    divider_value_o,
  output logic [63:0]         achieved_period_ns_o
);

  logic [PERIOD_W-1:0] period_q, ticks_q, counts_q;
  logic [63:0]         prod_q;
  logic [ACC_W-1:0]    acc_q;
  logic [DIV_W-1:0]    cand_q, lo_q, hi_q, one_w, limit_w, mid_w, cand_d;
  logic [DIV_W:0]      lim_full, mid_sum;
  logic [5:0]          wsum;
  logic [31:0]         mul_a, mul_b;
  logic [ACC_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic                div_done, div_ovf;
  logic [63:0]         div_quo;
  logic                valid_q, status_q;
  logic [TOP_W-1:0]    top_q;
  logic [DIV_W-1:0]    dval_q;
  logic [63:0]         ach_q;

  assign wsum     = {1'b0, cfg_i.divider_int_width} + {1'b0, cfg_i.divider_frac_width};
  assign one_w    = DIV_W'(1) << cfg_i.divider_frac_width;
  assign lim_full = ((DIV_W+1)'(1) << wsum) - (DIV_W+1)'(1);
  assign limit_w  = lim_full[DIV_W-1:0];
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w    = mid_sum[DIV_W:1];

  always_comb begin
    sts_o.cfg_ok = (cfg_i.clk_freq != '0)
                && (!cfg_i.clk_freq[CLOCK_W-1] || cfg_i.clk_freq[CLOCK_W-2:0] == '0)
                && (cfg_i.counter_width >= CW_W'(2))
                && (cfg_i.counter_width <= CW_W'(MAX_COUNTER_BITS))
                && (cfg_i.divider_int_width != '0)
                && (cfg_i.divider_frac_width <= FW_W'(MAX_FRAC_BITS))
                && (wsum <= 6'(MAX_DIVIDER_BITS));
    sts_o.period_nz = period_q != '0;
    sts_o.ticks_ovf = acc_q[ACC_W-1:64] != '0;
    sts_o.div_done  = div_done;
    sts_o.div_ovf   = div_ovf;
    sts_o.cnt_ge2   = counts_q[63:1] != '0;
    sts_o.cnt_fits  = (counts_q >> cfg_i.counter_width) == '0;
    sts_o.lo_lt_hi  = lo_q < hi_q;
  end

  // Operand select for the shared 32x32 multiplier
  always_comb begin
    mul_a = period_q[31:0];
    mul_b = cfg_i.clk_freq[31:0];
    case (cmd_i.mul_sel)
      MUL_PC_LO: begin mul_a = period_q[31:0];          mul_b = cfg_i.clk_freq[31:0]; end
      MUL_PC_HI: begin mul_a = period_q[63:32];         mul_b = cfg_i.clk_freq[31:0]; end
      MUL_CAND:  begin mul_a = {8'd0, cand_q};          mul_b = NS_PER_SEC; end
      MUL_CL:    begin mul_a = counts_q[31:0];          mul_b = {8'd0, lo_q}; end
      MUL_M_LO:  begin mul_a = acc_q[31:0];             mul_b = NS_PER_SEC; end
      MUL_M_HI:  begin mul_a = acc_q[63:32];            mul_b = NS_PER_SEC; end
      default:   ;
    endcase
  end

  always_comb begin
    case (cmd_i.cand_sel)
      CAND_ONE:   cand_d = one_w;
      CAND_LIMIT: cand_d = limit_w;
      CAND_MID:   cand_d = mid_w;
      default:    cand_d = lo_q;
    endcase
  end

  always_comb begin
    if (cmd_i.den_sel == DEN_CAND) begin
      div_num = {32'd0, ticks_q} << cfg_i.divider_frac_width;
      div_den = prod_q[DEN_W-1:0];
    end else begin
      div_num = acc_q;
      div_den = {{(DEN_W-CLOCK_W){1'b0}}, cfg_i.clk_freq} << cfg_i.divider_frac_width;
    end
  end

  pwm_pdp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.ld_period) period_q <= period_ns_i;
    case (cmd_i.acc_op)
      ACC_LOAD:   acc_q <= {32'd0, prod_q};
      ACC_ADD_HI: acc_q <= acc_q + {prod_q, 32'd0};
      ACC_TICKS:  acc_q <= cfg_i.clk_freq[CLOCK_W-1] ? {period_q, 32'd0}
                                                     : acc_q + {prod_q, 32'd0};
      default:    ;
    endcase
    if (cmd_i.ld_ticks)  ticks_q  <= acc_q[63:0];
    if (cmd_i.ld_cand)   cand_q   <= cand_d;
    if (cmd_i.ld_counts) counts_q <= div_quo;
    if (cmd_i.srch_init) begin
      lo_q <= one_w;
      hi_q <= limit_w;
    end
    if (cmd_i.srch_hi) hi_q <= cand_q;
    if (cmd_i.srch_lo) lo_q <= cand_q + DIV_W'(1);
    if (cmd_i.res_ok) begin
      status_q <= 1'b0;
      top_q    <= counts_q[TOP_W-1:0] - TOP_W'(1);
      dval_q   <= lo_q;
      ach_q    <= div_quo;
    end else if (cmd_i.res_err) begin
      status_q <= 1'b1;
      top_q    <= '0;
      dval_q   <= '0;
      ach_q    <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= cmd_i.res_ok | cmd_i.res_err;
  end

  assign result_valid_o       = valid_q;
  assign status_o             = status_q;
  assign top_value_o          = top_q;
  assign divider_value_o      = dval_q;
  assign achieved_period_ns_o = ach_q;

endmodule

FILE: rtl/pwm_pdp_ctrl.sv
// Controller: sequences tick product, bisection over dividers and final period.
module pwm_pdp_ctrl import pwm_pdp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_CHECK   = 20'h00002,
    ST_PT_LO   = 20'h00004,
    ST_PT_HI   = 20'h00008,
    ST_PT_SUM  = 20'h00010,
    ST_PT_CHK  = 20'h00020,
    ST_CF_MUL  = 20'h00040,
    ST_CF_DIV  = 20'h00080,
    ST_CF_WAIT = 20'h00100,
    ST_CF_EVAL = 20'h00200,
    ST_SRCH    = 20'h00400,
    ST_FM_CL   = 20'h00800,
    ST_FM_LD   = 20'h01000,
    ST_FM_LO   = 20'h02000,
    ST_FM_HI   = 20'h04000,
    ST_FM_SUM  = 20'h08000,
    ST_FM_DIV  = 20'h10000,
    ST_FM_WAIT = 20'h20000,
    ST_OK      = 20'h40000,
    ST_FAIL    = 20'h80000
  } state_e;

  typedef enum logic [1:0] {
    PH_ONE,
    PH_LIMIT,
    PH_SEARCH,
    PH_FINAL
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.mul_sel  = MUL_PC_LO;
    cmd_o.acc_op   = ACC_HOLD;
    cmd_o.cand_sel = CAND_ONE;
    cmd_o.den_sel  = DEN_CAND;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.ld_period = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: state_d = (sts_i.cfg_ok && sts_i.period_nz) ? ST_PT_LO : ST_FAIL;
      ST_PT_LO: begin
        cmd_o.mul_sel = MUL_PC_LO;
        state_d = ST_PT_HI;
      end
      ST_PT_HI: begin
        cmd_o.mul_sel = MUL_PC_HI;
        cmd_o.acc_op  = ACC_LOAD;
        state_d = ST_PT_SUM;
      end
      ST_PT_SUM: begin
        cmd_o.acc_op = ACC_TICKS;
        state_d = ST_PT_CHK;
      end
      ST_PT_CHK: begin
        if (sts_i.ticks_ovf) begin
          state_d = ST_FAIL;
        end else begin
          cmd_o.ld_ticks = 1'b1;
          cmd_o.ld_cand  = 1'b1;
          cmd_o.cand_sel = CAND_ONE;
          phase_d = PH_ONE;
          state_d = ST_CF_MUL;
        end
      end
      ST_CF_MUL: begin
        cmd_o.mul_sel = MUL_CAND;
        state_d = ST_CF_DIV;
      end
      ST_CF_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.den_sel   = DEN_CAND;
        state_d = ST_CF_WAIT;
      end
      ST_CF_WAIT: begin
        if (sts_i.div_done) begin
          if (sts_i.div_ovf) begin
            state_d = ST_FAIL;
          end else begin
            cmd_o.ld_counts = 1'b1;
            state_d = ST_CF_EVAL;
          end
        end
      end
      ST_CF_EVAL: begin
        case (phase_q)
          PH_ONE: begin
            if (!sts_i.cnt_ge2) begin
              state_d = ST_FAIL;
            end else begin
              cmd_o.ld_cand  = 1'b1;
              cmd_o.cand_sel = CAND_LIMIT;
              phase_d = PH_LIMIT;
              state_d = ST_CF_MUL;
            end
          end
          PH_LIMIT: begin
            if (!sts_i.cnt_fits) begin
              state_d = ST_FAIL;
            end else begin
              cmd_o.srch_init = 1'b1;
              state_d = ST_SRCH;
            end
          end
          PH_SEARCH: begin
            // Fits: shrink from above; else the answer lies past the midpoint
            cmd_o.srch_hi = sts_i.cnt_fits;
            cmd_o.srch_lo = !sts_i.cnt_fits;
            state_d = ST_SRCH;
          end
          default: begin
            state_d = (sts_i.cnt_ge2 && sts_i.cnt_fits) ? ST_FM_CL : ST_FAIL;
          end
        endcase
      end
      ST_SRCH: begin
        cmd_o.ld_cand = 1'b1;
        if (sts_i.lo_lt_hi) begin
          cmd_o.cand_sel = CAND_MID;
          phase_d = PH_SEARCH;
        end else begin
          cmd_o.cand_sel = CAND_LO;
          phase_d = PH_FINAL;
        end
        state_d = ST_CF_MUL;
      end
      ST_FM_CL: begin
        cmd_o.mul_sel = MUL_CL;
        state_d = ST_FM_LD;
      end
      ST_FM_LD: begin
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_FM_LO;
      end
      ST_FM_LO: begin
        cmd_o.mul_sel = MUL_M_LO;
        state_d = ST_FM_HI;
      end
      ST_FM_HI: begin
        cmd_o.mul_sel = MUL_M_HI;
        cmd_o.acc_op  = ACC_LOAD;
        state_d = ST_FM_SUM;
      end
      ST_FM_SUM: begin
        cmd_o.acc_op = ACC_ADD_HI;
        state_d = ST_FM_DIV;
      end
      ST_FM_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.den_sel   = DEN_CLOCK;
        state_d = ST_FM_WAIT;
      end
      ST_FM_WAIT: begin
        cmd_o.den_sel = DEN_CLOCK;
        if (sts_i.div_done) state_d = sts_i.div_ovf ? ST_FAIL : ST_OK;
      end
      ST_OK: begin
        cmd_o.res_ok = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FAIL: begin
        cmd_o.res_err = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_ONE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign busy = state_q != ST_IDLE;

endmodule

FILE: rtl/pwm_period_divider_planner_core.sv
// Top level of the PWM period divider planner: register file, controller and datapath.
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------------
// request   | start / busy               | period_ns_i
// result    | result_valid_o (1 cycle)   | status_o, top_value_o, divider_value_o,
//           |                            | achieved_period_ns_o
// config    | psel/penable/pwrite/pready | paddr (reg index in [4:3]), pwdata, prdata
//
// Sequence: each rounded multiply-divide runs through the one-bit-per-cycle divider (64
// quotient steps plus start, rounding and done). A plan runs two bound checks, one
// bisection step per bit of the divider range (up to 24), one final count and the period;
// a narrow divider range finishes sooner. A bad configuration or zero period passes only
// through the check and fail states before its result strobes.
// Reset: rst_ni clears the controller and loads the register defaults (125 MHz clock,
// 16-bit counter, 8 integer and 4 fraction divider bits).
// Stalls: busy stays high from the accepted transaction until its result strobes; the
// receiver cannot stall, so the result shows for exactly one cycle.
module pwm_period_divider_planner_core import pwm_pdp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request
  input  logic                start,
  output logic                busy,
  input  logic [PERIOD_W-1:0] period_ns_i,
  // result
  output logic                result_valid_o,
  output logic                status_o,
  output logic [TOP_W-1:0]    top_value_o,
  output logic [DIV_W-1:0]    divider_value_o,
  output logic [63:0]         achieved_period_ns_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       wr_en;
  logic [1:0] reg_idx;

  // Registers are 8 bytes apart; the low address bits are ignored
  assign reg_idx = paddr[APB_AW-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clk_freq           <= CLK_FREQ_RST;
      cfg_q.counter_width      <= CNT_WIDTH_RST;
      cfg_q.divider_int_width  <= INT_WIDTH_RST;
      cfg_q.divider_frac_width <= FRC_WIDTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CLK_FREQ:  cfg_q.clk_freq           <= pwdata[CLOCK_W-1:0];
        REG_CNT_WIDTH: cfg_q.counter_width      <= pwdata[CW_W-1:0];
        REG_INT_WIDTH: cfg_q.divider_int_width  <= pwdata[IW_W-1:0];
        REG_FRC_WIDTH: cfg_q.divider_frac_width <= pwdata[FW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the register selected by the address
  always_comb begin
    unique case (reg_idx)
      REG_CLK_FREQ:  prdata = {{(APB_DW-CLOCK_W){1'b0}}, cfg_q.clk_freq};
      REG_CNT_WIDTH: prdata = {{(APB_DW-CW_W){1'b0}}, cfg_q.counter_width};
      REG_INT_WIDTH: prdata = {{(APB_DW-IW_W){1'b0}}, cfg_q.divider_int_width};
      REG_FRC_WIDTH: prdata = {{(APB_DW-FW_W){1'b0}}, cfg_q.divider_frac_width};
      default:       prdata = '0;
    endcase
  end

  // Controller walks the plan; it only issues commands and reads status
  pwm_pdp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath holds operands, the shared multiplier, the divider and the result
  pwm_pdp_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .period_ns_i          (period_ns_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .result_valid_o       (result_valid_o),
    .status_o             (status_o),
    .top_value_o          (top_value_o),
    .divider_value_o      (divider_value_o),
    .achieved_period_ns_o (achieved_period_ns_o)
  );

endmodule

FILE: tb/pwm_pdp_checker.sv
// Checker for the PWM period divider planner: tracks registers, predicts plans, compares results.
module pwm_pdp_checker import pwm_pdp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic [PERIOD_W-1:0] period_ns_i,
  input  logic                result_valid_o,
  input  logic                status_o,
  input  logic [TOP_W-1:0]    top_value_o,
  input  logic [DIV_W-1:0]    divider_value_o,
  input  logic [63:0]         achieved_period_ns_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output int                  fail_count,
  output int                  plans_pending,
  output int                  plans_solved
);

  typedef struct {
    bit        status;
    bit [31:0] top;
    bit [23:0] divider;
    bit [63:0] achieved;
  } plan_t;

  cfg_t  cfg;
  plan_t plan_q[$];

  // floor(a*b/c) and remainder, digit by digit in radix 256
  function automatic bit scaled_div(input bit [63:0] a, b, c, output bit [63:0] q, r);
    bit [63:0] cur, d;
    q = 0;
    r = 0;
    if (c == 0) return 0;
    for (int pos = 56; pos >= 0; pos -= 8) begin
      cur = r * 64'd256 + ((a >> pos) & 64'hff) * b;
      d   = cur / c;
      r   = cur % c;
      if (q > (64'hffff_ffff_ffff_ffff - d) / 64'd256) return 0;
      q = q * 64'd256 + d;
    end
    return 1;
  endfunction

  function automatic bit scaled_div_round(input bit [63:0] a, b, c, output bit [63:0] res);
    bit [63:0] q, r;
    res = 0;
    if (!scaled_div(a, b, c, q, r)) return 0;
    if (2 * r >= c) begin
      if (q == 64'hffff_ffff_ffff_ffff) return 0;
      q++;
    end
    res = q;
    return 1;
  endfunction

  function automatic bit solve_plan(input bit [63:0] period, output plan_t p);
    bit [63:0] clk, cw, iw, fw, one, limit, most, ticks, at_one, cnt_at_max, lo, hi, mid;
    bit [63:0] counts, act;
    p   = '{status: 1, top: 0, divider: 0, achieved: 0};
    clk = 64'(cfg.clk_freq);
    cw  = 64'(cfg.counter_width);
    iw  = 64'(cfg.divider_int_width);
    fw  = 64'(cfg.divider_frac_width);
    if (clk == 0 || clk > 64'h1_0000_0000 || period == 0) return 0;
    if (cw < 2 || cw > MAX_COUNTER_BITS || iw < 1 || fw > MAX_FRAC_BITS ||
        iw + fw > MAX_DIVIDER_BITS) return 0;
    one   = 64'd1 << fw;
    limit = (64'd1 << (iw + fw)) - 1;
    most  = (64'd1 << cw) - 1;
    if (period > 64'hffff_ffff_ffff_ffff / clk) return 0;
    ticks = period * clk;
    if (!scaled_div_round(ticks, one, one * NS_PER_SEC, at_one)) return 0;
    if (!scaled_div_round(ticks, one, limit * NS_PER_SEC, cnt_at_max)) return 0;
    if (at_one < 2 || cnt_at_max > most) return 0;
    lo = one;
    hi = limit;
    // bisect for the smallest divider whose count still fits
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!scaled_div_round(ticks, one, mid * NS_PER_SEC, counts)) return 0;
      if (counts <= most) hi = mid;
      else lo = mid + 1;
    end
    if (!scaled_div_round(ticks, one, lo * NS_PER_SEC, counts)) return 0;
    if (counts < 2 || counts > most) return 0;
    if (!scaled_div_round(counts * lo, NS_PER_SEC, one * clk, act)) return 0;
    p = '{status: 0, top: counts[31:0] - 1, divider: lo[23:0], achieved: act};
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plan_t p, e;
    int    errs;
    if (!rst_ni) begin
      cfg <= '{CLK_FREQ_RST, CNT_WIDTH_RST, INT_WIDTH_RST, FRC_WIDTH_RST};
      fail_count    <= 0;
      plans_pending <= 0;
      plans_solved  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_CLK_FREQ:  cfg.clk_freq           <= pwdata[CLOCK_W-1:0];
          REG_CNT_WIDTH: cfg.counter_width      <= pwdata[CW_W-1:0];
          REG_INT_WIDTH: cfg.divider_int_width  <= pwdata[IW_W-1:0];
          REG_FRC_WIDTH: cfg.divider_frac_width <= pwdata[FW_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        void'(solve_plan(period_ns_i, p));
        plan_q.push_back(p);
      end
      if (result_valid_o) begin
        errs = 0;
        if (plan_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          e = plan_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errs++;
          end
          if (top_value_o !== e.top) begin
            $error("top_value: expected %0d, got %0d", e.top, top_value_o);
            errs++;
          end
          if (divider_value_o !== e.divider) begin
            $error("divider_value: expected %0d, got %0d", e.divider, divider_value_o);
            errs++;
          end
          if (achieved_period_ns_o !== e.achieved) begin
            $error("achieved_period_ns: expected %0d, got %0d", e.achieved,
                   achieved_period_ns_o);
            errs++;
          end
          if (!e.status) plans_solved <= plans_solved + 1;
        end
        fail_count <= fail_count + errs;
      end
      plans_pending <= plan_q.size();
    end
  end

endmodule

FILE: tb/tb_pwm_period_divider_planner_core.sv
// Testbench top for the PWM period divider planner: stimulus, register writes and verdict.
module tb_pwm_period_divider_planner_core;
  import pwm_pdp_pkg::*;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                start = 0;
  logic                busy;
  logic [PERIOD_W-1:0] period_ns_i = '0;
  logic                result_valid_o, status_o;
  logic [TOP_W-1:0]    top_value_o;
  logic [DIV_W-1:0]    divider_value_o;
  logic [63:0]         achieved_period_ns_o;
  logic                psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  int                  fail_count, plans_pending, plans_solved;
  int                  idle_pct = 24;
  int                  n_requests = 0, n_settings = 0;

  // clock: period of 2 time units
  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  pwm_period_divider_planner_core dut (.*);

  pwm_pdp_checker u_checker (.*);

  // wait out any random idle, then hold the request until the block takes it
  task automatic request_plan(input logic [63:0] period);
    if ($urandom_range(99) < idle_pct)
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        start <= 0;
      end
    @(negedge clk_i);
    start       <= 1;
    period_ns_i <= period;
    #0;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    n_requests++;
  endtask

  // drop start, then drain outstanding transactions before touching registers
  task automatic drain;
    @(negedge clk_i);
    start <= 0;
    while (plans_pending != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  task automatic set_config(input logic [63:0] clk_hz, input int cw, iw, fw);
    drain();
    write_reg(REG_CLK_FREQ, clk_hz);
    write_reg(REG_CNT_WIDTH, 64'(cw));
    write_reg(REG_INT_WIDTH, 64'(iw));
    write_reg(REG_FRC_WIDTH, 64'(fw));
    n_settings++;
  endtask

  // periods spread over every magnitude so every bit toggles
  function automatic logic [63:0] random_period();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  initial begin
    logic [63:0] clk_hz;
    int cw, iw, fw;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: reset setting, zero, tiny, huge, typical periods
    request_plan(64'd0);
    request_plan(64'd1);
    request_plan(64'd16);
    request_plan(64'd20_000);
    request_plan(64'd1_000_000);
    request_plan(64'd8_388_608_000);
    request_plan(64'hffff_ffff_ffff_ffff);
    // hold off until the block is empty at least once mid-run
    drain();
    request_plan(64'd2_000_000_000);

    // directed: extreme and invalid settings
    set_config(64'd1, 32, 24, 0);
    request_plan(64'd3_000_000_000);
    request_plan(64'hffff_ffff_ffff_ffff);
    set_config(64'h1_0000_0000, 2, 1, 0);
    request_plan(64'd1);
    request_plan(64'hffff_ffff);
    set_config(64'h1_0000_0000, 32, 8, 16);
    request_plan(64'd1_000_000);
    request_plan(64'hffff_ffff_ffff_ffff);
    set_config(64'd0, 16, 8, 4);
    request_plan(64'd20_000);
    set_config(64'h1_ffff_ffff, 16, 8, 4);
    request_plan(64'd20_000);
    set_config(64'd50_000_000, 1, 8, 4);
    request_plan(64'd20_000);
    set_config(64'd50_000_000, 63, 0, 31);
    request_plan(64'd20_000);
    set_config(64'd50_000_000, 33, 31, 17);
    request_plan(64'd20_000);
    set_config(64'd50_000_000, 16, 9, 16);
    request_plan(64'd20_000);

    // random phases: mostly valid settings, a few broken ones, one phase with no idling
    for (int ph = 0; ph < 9; ph++) begin
      clk_hz = $urandom_range(0, 9) == 0 ? {31'd0, 1'b1, 32'($urandom)}
             : 64'($urandom_range(1, 32'hffff_ffff)) >> $urandom_range(0, 24);
      cw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(2, 32);
      iw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
      fw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
         : $urandom_range(0, (24 - iw) < 16 ? 24 - iw : 16);
      set_config(clk_hz, cw, iw, fw);
      idle_pct = (ph == 4) ? 0 : 24;
      repeat (30) request_plan(random_period());
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d plan requests over %0d register settings, %0d solved",
             n_requests, n_settings, plans_solved);
    if (fail_count == 0)
      $display("tb_pwm_period_divider_planner_core passed");
    else
      $display("tb_pwm_period_divider_planner_core failed");
    $finish;
  end

  // timeout: far beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("tb_pwm_period_divider_planner_core failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/pwm_pdp_pkg.sv
rtl/pwm_pdp_div.sv
rtl/pwm_pdp_dp.sv
rtl/pwm_pdp_ctrl.sv
rtl/pwm_period_divider_planner_core.sv
tb/pwm_pdp_checker.sv
tb/tb_pwm_period_divider_planner_core.sv
